>>> rtl/isc_pkg.sv
// Shared types, character codes and scan functions of the ini syntax checker.
package isc_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] MARK_BYTE0  = 8'hEF;
    localparam logic [7:0] MARK_BYTE1  = 8'hBB;
    localparam logic [7:0] MARK_BYTE2  = 8'hBF;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_SEMI   = 8'h3B;
    localparam logic [7:0] CHAR_LBRACK = 8'h5B;
    localparam logic [7:0] CHAR_RBRACK = 8'h5D;
    localparam logic [7:0] CHAR_EQUALS = 8'h3D;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_QUOTE  = 8'h22;

    typedef enum logic [1:0] {
        MARK_NONE,
        MARK_EF,
        MARK_EFBB,
        MARK_DONE
    } mark_state_t;

    typedef enum logic [3:0] {
        CLS_OTHER,
        CLS_BLANK,
        CLS_LF,
        CLS_CR,
        CLS_SEMI,
        CLS_LBRACK,
        CLS_RBRACK,
        CLS_EQUALS,
        CLS_BSLASH,
        CLS_QUOTE
    } byte_class_t;

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_PENDING,
        ESC_LF,
        ESC_CR
    } esc_state_t;

    typedef enum logic [1:0] {
        FAULT_NONE,
        FAULT_SECTION,
        FAULT_EQUALS
    } fault_t;

    // One queued transaction: held mark bytes to replay, then an optional byte.
    typedef struct packed {
        logic [1:0]  pre_count;
        logic        has_byte;
        byte_class_t cls;
        logic        last;
    } entry_t;

    typedef struct packed {
        logic       line_open;
        logic       section_line;
        logic       bracket_seen;
        logic       equals_seen;
        logic       quoted;
        logic       comment_active;
        esc_state_t escape_stage;
        fault_t     fault_latch;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        line_open:      1'b0,
        section_line:   1'b0,
        bracket_seen:   1'b0,
        equals_seen:    1'b0,
        quoted:         1'b0,
        comment_active: 1'b0,
        escape_stage:   ESC_NONE,
        fault_latch:    FAULT_NONE
    };

    function automatic byte_class_t classify(input logic [7:0] b);
        byte_class_t c;
        priority if (b == CHAR_SPACE || b == CHAR_TAB) c = CLS_BLANK;
        else if (b == CHAR_LF)     c = CLS_LF;
        else if (b == CHAR_CR)     c = CLS_CR;
        else if (b == CHAR_SEMI)   c = CLS_SEMI;
        else if (b == CHAR_LBRACK) c = CLS_LBRACK;
        else if (b == CHAR_RBRACK) c = CLS_RBRACK;
        else if (b == CHAR_EQUALS) c = CLS_EQUALS;
        else if (b == CHAR_BSLASH) c = CLS_BSLASH;
        else if (b == CHAR_QUOTE)  c = CLS_QUOTE;
        else                       c = CLS_OTHER;
        return c;
    endfunction

    function automatic scan_state_t judge_line(input scan_state_t s);
        scan_state_t r;
        fault_t      kind;
        r    = s;
        kind = FAULT_NONE;
        if (s.section_line)
        begin
            if (!s.bracket_seen)
                kind = FAULT_SECTION;
        end
        else if (!s.equals_seen)
        begin
            kind = FAULT_EQUALS;
        end
        if (s.fault_latch == FAULT_NONE)
            r.fault_latch = kind;
        r.line_open = 1'b0;
        return r;
    endfunction

    function automatic scan_state_t scan_byte(input scan_state_t s, input byte_class_t c);
        scan_state_t r;
        logic        done;
        logic        is_eol;
        r      = s;
        done   = 1'b0;
        is_eol = (c == CLS_LF) || (c == CLS_CR);
        if (s.escape_stage == ESC_PENDING)
        begin
            if (s.section_line && c == CLS_RBRACK)
                r.bracket_seen = 1'b1;
            r.escape_stage = (c == CLS_LF) ? ESC_LF : (c == CLS_CR) ? ESC_CR : ESC_NONE;
            done = 1'b1;
        end
        else if (s.escape_stage != ESC_NONE)
        begin
            // escaped line break: eat its partner
            r.escape_stage = ESC_NONE;
            if ((s.escape_stage == ESC_LF && c == CLS_CR) ||
                (s.escape_stage == ESC_CR && c == CLS_LF))
                done = 1'b1;
        end
        if (!done && r.comment_active)
        begin
            if (is_eol)
                r.comment_active = 1'b0;
            done = 1'b1;
        end
        if (!done && !r.line_open)
        begin
            if (c == CLS_BLANK || is_eol)
            begin
                done = 1'b1;
            end
            else if (c == CLS_SEMI)
            begin
                r.comment_active = 1'b1;
                done = 1'b1;
            end
            else
            begin
                r.line_open    = 1'b1;
                r.section_line = (c == CLS_LBRACK);
                r.bracket_seen = 1'b0;
                r.equals_seen  = 1'b0;
                r.quoted       = 1'b0;
            end
        end
        if (!done)
        begin
            if (r.section_line && c == CLS_RBRACK)
                r.bracket_seen = 1'b1;
            case (c)
                CLS_EQUALS:
                begin
                    if (!r.quoted)
                        r.equals_seen = 1'b1;
                end
                CLS_LF, CLS_CR:
                begin
                    if (!r.quoted)
                        r = judge_line(r);
                end
                CLS_BSLASH: r.escape_stage = ESC_PENDING;
                CLS_QUOTE:  r.quoted = !r.quoted;
                CLS_SEMI:
                begin
                    if (!r.quoted)
                    begin
                        r = judge_line(r);
                        r.comment_active = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        return r;
    endfunction

endpackage

>>> rtl/isc_front.sv
// Front end: byte order mark handling and byte classification.
module isc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              byte_valid,
    input  logic              last,
    output logic              push,
    output isc_pkg::entry_t   entry
);

    isc_pkg::mark_state_t mark_reg, mark_next;
    isc_pkg::mark_state_t mark_after;
    logic [1:0]           pre_count;
    logic [1:0]           held_count;
    logic                 scan_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mark_reg <= isc_pkg::MARK_NONE;
        else
            mark_reg <= mark_next;
    end

    always_comb
    begin
        mark_after = mark_reg;
        pre_count  = 2'd0;
        scan_b     = 1'b0;
        if (byte_valid)
        begin
            unique case (mark_reg)
                isc_pkg::MARK_NONE:
                begin
                    if (data_byte == isc_pkg::MARK_BYTE0)
                        mark_after = isc_pkg::MARK_EF;
                    else
                    begin
                        mark_after = isc_pkg::MARK_DONE;
                        scan_b     = 1'b1;
                    end
                end
                isc_pkg::MARK_EF:
                begin
                    if (data_byte == isc_pkg::MARK_BYTE1)
                        mark_after = isc_pkg::MARK_EFBB;
                    else
                    begin
                        mark_after = isc_pkg::MARK_DONE;
                        pre_count  = 2'd1;
                        scan_b     = 1'b1;
                    end
                end
                isc_pkg::MARK_EFBB:
                begin
                    mark_after = isc_pkg::MARK_DONE;
                    if (data_byte != isc_pkg::MARK_BYTE2)
                    begin
                        pre_count = 2'd2;
                        scan_b    = 1'b1;
                    end
                end
                isc_pkg::MARK_DONE: scan_b = 1'b1;
            endcase
        end

        // at end of file a partial mark turns back into text
        held_count = 2'd0;
        if (last)
        begin
            if (mark_after == isc_pkg::MARK_EF)
                held_count = 2'd1;
            else if (mark_after == isc_pkg::MARK_EFBB)
                held_count = 2'd2;
        end

        entry.pre_count = pre_count | held_count;
        entry.has_byte  = scan_b;
        entry.cls       = isc_pkg::classify(data_byte);
        entry.last      = last;

        push      = accept && (scan_b || pre_count != 2'd0 || last);
        mark_next = mark_reg;
        if (accept)
            mark_next = last ? isc_pkg::MARK_NONE : mark_after;
    end

    property p_mark_restarts;
        @(posedge clk) disable iff (!rst_n)
        (accept && last) |=> (mark_reg == isc_pkg::MARK_NONE);
    endproperty
    a_mark_restarts: assert property (p_mark_restarts)
        else $error("mark stage not cleared after end of file");

endmodule

>>> rtl/isc_queue.sv
// Short queue of classified transactions between front and back end.
module isc_queue #(
    parameter int DEPTH = isc_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  isc_pkg::entry_t push_entry,
    input  logic            pop,
    output logic            full,
    output logic            head_valid,
    output isc_pkg::entry_t head_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    isc_pkg::entry_t   slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    property p_no_overflow;
        @(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop);
    endproperty
    a_no_overflow: assert property (p_no_overflow)
        else $error("push into a full queue");

    property p_no_underflow;
        @(posedge clk) disable iff (!rst_n)
        pop |-> head_valid;
    endproperty
    a_no_underflow: assert property (p_no_underflow)
        else $error("pop from an empty queue");

    property p_count_tracks;
        @(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg == $past(count_reg + CNT_W'(push) - CNT_W'(pop)));
    endproperty
    a_count_tracks: assert property (p_count_tracks)
        else $error("queue fill count out of step with push and pop");

endmodule

>>> rtl/isc_back.sv
// Back end: line scanner, fault latch and verdict output register.
module isc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  isc_pkg::entry_t head_entry,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic            malformed,
    output logic [1:0]      fault_kind
);

    isc_pkg::scan_state_t scan_reg, scan_next;
    isc_pkg::scan_state_t step1, step2, step3, judged;
    logic                 out_valid_reg, out_valid_next;
    isc_pkg::fault_t      fault_reg, fault_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg      <= isc_pkg::SCAN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fault_reg <= fault_next;
    end

    always_comb
    begin
        // a verdict may only leave the queue when the output register frees up
        pop = head_valid && (!head_entry.last || !out_valid_reg || !out_stall);

        // replay held mark bytes, then the byte itself
        step1 = (head_entry.pre_count != 2'd0)
              ? isc_pkg::scan_byte(scan_reg, isc_pkg::CLS_OTHER) : scan_reg;
        step2 = (head_entry.pre_count == 2'd2)
              ? isc_pkg::scan_byte(step1, isc_pkg::CLS_OTHER) : step1;
        step3 = head_entry.has_byte ? isc_pkg::scan_byte(step2, head_entry.cls) : step2;
        judged = (step3.line_open && !step3.comment_active)
               ? isc_pkg::judge_line(step3) : step3;

        scan_next      = scan_reg;
        fault_next     = fault_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (pop)
        begin
            if (head_entry.last)
            begin
                scan_next      = isc_pkg::SCAN_RESET;
                fault_next     = judged.fault_latch;
                out_valid_next = 1'b1;
            end
            else
            begin
                scan_next = step3;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign malformed  = (fault_reg != isc_pkg::FAULT_NONE);
    assign fault_kind = fault_reg;

    property p_fresh_after_verdict;
        @(posedge clk) disable iff (!rst_n)
        (pop && head_entry.last) |=> (scan_reg == isc_pkg::SCAN_RESET);
    endproperty
    a_fresh_after_verdict: assert property (p_fresh_after_verdict)
        else $error("scan state not cleared after a verdict");

    property p_escape_in_line;
        @(posedge clk) disable iff (!rst_n)
        (scan_reg.escape_stage != isc_pkg::ESC_NONE)
            |-> (scan_reg.line_open && !scan_reg.comment_active);
    endproperty
    a_escape_in_line: assert property (p_escape_in_line)
        else $error("escape pending outside an open line");

endmodule

>>> rtl/ini_syntax_checker.sv
// Top level of the streaming ini file syntax checker.
//
// Takes one byte of the file per clock cycle while in_stall is low, with no
// gaps needed between transactions, and returns one verdict transaction for
// each input marked last: malformed plus the kind of the first bad line. The
// front end strips a leading EF BB BF mark and classifies each byte; the back
// end runs the line scanner, which handles one queued transaction per cycle,
// including up to two replayed mark bytes, unless a verdict waits on out_stall.
// A verdict passes through the queue and then the output register. The queue
// of QUEUE_DEPTH transactions lets the input keep flowing while a verdict waits
// on out_stall; in_stall rises only once that queue has filled.
module ini_syntax_checker #(
    parameter int QUEUE_DEPTH = isc_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       byte_valid,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       malformed,
    output logic [1:0] fault_kind
);

    logic            accept;
    logic            push;
    logic            pop;
    logic            full;
    logic            head_valid;
    isc_pkg::entry_t push_entry;
    isc_pkg::entry_t head_entry;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    isc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (data_byte),
        .byte_valid (byte_valid),
        .last       (last),
        .push       (push),
        .entry      (push_entry)
    );

    isc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    isc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .malformed  (malformed),
        .fault_kind (fault_kind)
    );

endmodule

>>> tb/sv/tb_ini_syntax_checker.sv
// Self-checking testbench for the streaming ini syntax checker: directed and random files.
module tb_ini_syntax_checker;
    import isc_pkg::*;

    localparam int ITEM_TARGET = 1650;
    localparam int STALL_LIMIT = 1000;
    localparam int TAIL_CYCLES = 8;

    typedef struct packed {
        logic   bad;
        fault_t kind;
    } verdict_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
    logic       out_valid;
    logic       out_stall;
    logic       malformed;
    logic [1:0] fault_kind;

    // scanner state mirrored by the predictor
    mark_state_t mark_q;
    logic        line_q;
    logic        sect_q;
    logic        brk_q;
    logic        eq_q;
    logic        quo_q;
    logic        cmt_q;
    esc_state_t  esc_q;
    fault_t      fault_q;

    verdict_t    expected_verdicts[$];
    verdict_t    head;
    logic [7:0]  file_bytes[$];
    string       word_chars = "abcdefxyzKLMN0129_.-";
    int          error_count = 0;
    int          items_sent = 0;
    int          quiet_cycles = 0;
    bit          idle_on = 1'b1;

    ini_syntax_checker uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .byte_valid (byte_valid),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .malformed  (malformed),
        .fault_kind (fault_kind)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void clear_scanner();
        mark_q  = MARK_NONE;
        line_q  = 1'b0;
        sect_q  = 1'b0;
        brk_q   = 1'b0;
        eq_q    = 1'b0;
        quo_q   = 1'b0;
        cmt_q   = 1'b0;
        esc_q   = ESC_NONE;
        fault_q = FAULT_NONE;
    endfunction

    function automatic void close_line();
        fault_t kind;
        kind = FAULT_NONE;
        if (sect_q)
        begin
            if (!brk_q)
                kind = FAULT_SECTION;
        end
        else if (!eq_q)
        begin
            kind = FAULT_EQUALS;
        end
        if (fault_q == FAULT_NONE)
            fault_q = kind;
        line_q = 1'b0;
    endfunction

    function automatic void scan_char(input logic [7:0] b);
        logic eol;
        logic swallow;
        eol = (b == CHAR_LF) || (b == CHAR_CR);
        if (esc_q == ESC_PENDING)
        begin
            if (sect_q && b == CHAR_RBRACK)
                brk_q = 1'b1;
            if (b == CHAR_LF)
                esc_q = ESC_LF;
            else if (b == CHAR_CR)
                esc_q = ESC_CR;
            else
                esc_q = ESC_NONE;
            return;
        end
        if (esc_q != ESC_NONE)
        begin
            // an escaped line break also eats its partner
            swallow = (esc_q == ESC_LF && b == CHAR_CR) || (esc_q == ESC_CR && b == CHAR_LF);
            esc_q = ESC_NONE;
            if (swallow)
                return;
        end
        if (cmt_q)
        begin
            if (eol)
                cmt_q = 1'b0;
            return;
        end
        if (!line_q)
        begin
            if (b == CHAR_SPACE || b == CHAR_TAB || eol)
                return;
            if (b == CHAR_SEMI)
            begin
                cmt_q = 1'b1;
                return;
            end
            line_q = 1'b1;
            sect_q = (b == CHAR_LBRACK);
            brk_q  = 1'b0;
            eq_q   = 1'b0;
            quo_q  = 1'b0;
        end
        if (sect_q && b == CHAR_RBRACK)
            brk_q = 1'b1;
        case (b)
            CHAR_EQUALS:
            begin
                if (!quo_q)
                    eq_q = 1'b1;
            end
            CHAR_LF, CHAR_CR:
            begin
                if (!quo_q)
                    close_line();
            end
            CHAR_BSLASH: esc_q = ESC_PENDING;
            CHAR_QUOTE:  quo_q = !quo_q;
            CHAR_SEMI:
            begin
                if (!quo_q)
                begin
                    close_line();
                    cmt_q = 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    // replay held mark bytes as text
    function automatic void flush_held_mark();
        if (mark_q == MARK_EF || mark_q == MARK_EFBB)
            scan_char(MARK_BYTE0);
        if (mark_q == MARK_EFBB)
            scan_char(MARK_BYTE1);
        mark_q = MARK_DONE;
    endfunction

    function automatic void feed_byte(input logic [7:0] b);
        case (mark_q)
            MARK_NONE:
            begin
                if (b == MARK_BYTE0)
                begin
                    mark_q = MARK_EF;
                    return;
                end
                mark_q = MARK_DONE;
            end
            MARK_EF:
            begin
                if (b == MARK_BYTE1)
                begin
                    mark_q = MARK_EFBB;
                    return;
                end
                flush_held_mark();
            end
            MARK_EFBB:
            begin
                if (b == MARK_BYTE2)
                begin
                    mark_q = MARK_DONE;
                    return;
                end
                flush_held_mark();
            end
            default: ;
        endcase
        scan_char(b);
    endfunction

    function automatic void predict_item(input logic [7:0] b, input logic bv, input logic lst);
        verdict_t v;
        if (bv)
            feed_byte(b);
        if (lst)
        begin
            flush_held_mark();
            if (line_q && !cmt_q)
                close_line();
            v.bad  = (fault_q != FAULT_NONE);
            v.kind = fault_q;
            expected_verdicts.push_back(v);
            clear_scanner();
        end
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (expected_verdicts.size() == 0)
            begin
                report_mismatch("verdict with none pending, malformed", malformed, 0);
            end
            else
            begin
                head = expected_verdicts.pop_front();
                if (malformed !== head.bad)
                    report_mismatch("malformed", malformed, head.bad);
                if (fault_kind !== head.kind)
                    report_mismatch("fault_kind", fault_kind, head.kind);
            end
        end
    end

    // end the run when neither side moves a transaction for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("** ini_syntax_checker: FAILED **");
            $finish;
        end
    end

    // verdict receiver: random stall before each transaction
    initial
    begin
        int hold;
        out_stall <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            hold = idle_on ? $urandom_range(0, 15) : 0;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic send_item(input logic [7:0] b, input logic bv, input logic lst);
        int gap;
        gap = idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        byte_valid <= bv;
        last       <= lst;
        predict_item(b, bv, lst);
        if (bv || lst)
            items_sent++;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
    endtask

    task automatic send_text(input string s, input bit bare_end);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b1, !bare_end && i == s.len() - 1);
        if (bare_end)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // hold the input until every pending verdict has come back
    task automatic drain_verdicts();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_verdicts.size() != 0);
    endtask

    function automatic logic [7:0] pick_char();
        logic [7:0] c;
        case ($urandom_range(0, 31))
            0:       c = CHAR_EQUALS;
            1:       c = CHAR_QUOTE;
            2:       c = CHAR_BSLASH;
            3:       c = CHAR_RBRACK;
            4:       c = CHAR_SEMI;
            5:       c = 8'($urandom_range(0, 255));
            6:       c = CHAR_SPACE;
            default: c = word_chars[$urandom_range(0, word_chars.len() - 1)];
        endcase
        return c;
    endfunction

    function automatic void add_text(input int n);
        for (int i = 0; i < n; i++)
            file_bytes.push_back(pick_char());
    endfunction

    function automatic void add_line_end();
        case ($urandom_range(0, 4))
            0: file_bytes.push_back(CHAR_LF);
            1: file_bytes.push_back(CHAR_CR);
            2:
            begin
                file_bytes.push_back(CHAR_CR);
                file_bytes.push_back(CHAR_LF);
            end
            3:
            begin
                file_bytes.push_back(CHAR_LF);
                file_bytes.push_back(CHAR_CR);
            end
            default:
            begin
                file_bytes.push_back(CHAR_SEMI);
                add_text($urandom_range(0, 3));
                file_bytes.push_back(CHAR_LF);
            end
        endcase
    endfunction

    // mostly well-formed lines with random content, some broken lines and noise
    function automatic void build_random_file();
        int n_lines;
        file_bytes.delete();
        case ($urandom_range(0, 7))
            0:
            begin
                file_bytes.push_back(MARK_BYTE0);
                file_bytes.push_back(MARK_BYTE1);
                file_bytes.push_back(MARK_BYTE2);
            end
            1: file_bytes.push_back(MARK_BYTE0);
            2:
            begin
                file_bytes.push_back(MARK_BYTE0);
                file_bytes.push_back(MARK_BYTE1);
            end
            3:
            begin
                file_bytes.push_back(MARK_BYTE0);
                file_bytes.push_back(pick_char());
            end
            default: ;
        endcase
        n_lines = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 5);
        for (int i = 0; i < n_lines; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                file_bytes.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
            case ($urandom_range(0, 9))
                0: ;
                1:
                begin
                    file_bytes.push_back(CHAR_SEMI);
                    add_text($urandom_range(0, 5));
                end
                2, 3, 4:
                begin
                    add_text($urandom_range(1, 5));
                    file_bytes.push_back(CHAR_EQUALS);
                    add_text($urandom_range(0, 5));
                end
                5:
                begin
                    file_bytes.push_back(CHAR_LBRACK);
                    add_text($urandom_range(0, 4));
                    file_bytes.push_back(CHAR_RBRACK);
                    add_text($urandom_range(0, 2));
                end
                6:
                begin
                    file_bytes.push_back(CHAR_LBRACK);
                    add_text($urandom_range(0, 4));
                end
                7: add_text($urandom_range(1, 5));
                8:
                begin
                    repeat ($urandom_range(1, 6))
                        file_bytes.push_back(8'($urandom_range(0, 255)));
                end
                default:
                begin
                    file_bytes.push_back(CHAR_QUOTE);
                    add_text($urandom_range(0, 3));
                    file_bytes.push_back(CHAR_EQUALS);
                    file_bytes.push_back(CHAR_BSLASH);
                    file_bytes.push_back(pick_char());
                    file_bytes.push_back(CHAR_QUOTE);
                    if ($urandom_range(0, 1))
                        file_bytes.push_back(CHAR_EQUALS);
                    add_text($urandom_range(0, 3));
                end
            endcase
            if (i < n_lines - 1 || $urandom_range(0, 1))
                add_line_end();
        end
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_byte_order_mark();
        send_text("\357\273\277k=", 1'b0);
        send_text("\357\273x", 1'b0);
        send_text("\357", 1'b0);
    endtask

    task automatic test_line_rules();
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        send_text("[\\]", 1'b1);
        send_text("[\nq;", 1'b0);
        send_text("a\\\015\012=", 1'b0);
        send_text("\"=;\"\\", 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic test_drain_pause();
        send_text("x=1\n[s]", 1'b0);
        drain_verdicts();
        send_text("[s\n", 1'b1);
    endtask

    task automatic test_random_files();
        bit bare_end;
        while (items_sent < ITEM_TARGET)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            build_random_file();
            bare_end = (file_bytes.size() == 0) || ($urandom_range(0, 1) == 0);
            foreach (file_bytes[i])
            begin
                if ($urandom_range(0, 15) == 0)
                    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                send_item(file_bytes[i], 1'b1, !bare_end && i == file_bytes.size() - 1);
            end
            if (bare_end)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            if ($urandom_range(0, 19) == 0)
                drain_verdicts();
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        data_byte  <= 8'h00;
        byte_valid <= 1'b0;
        last       <= 1'b0;
        clear_scanner();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_byte_order_mark();
        test_line_rules();
        test_drain_pause();
        test_random_files();

        drain_verdicts();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_verdicts.size() != 0)
            report_mismatch("verdicts never delivered", 0, expected_verdicts.size());
        if (error_count == 0)
            $display("** ini_syntax_checker: PASSED **");
        else
            $display("** ini_syntax_checker: FAILED **");
        $finish;
    end

endmodule
